// ----- design/ittf_pkg.sv -----
// ----------------------------------------------------------------------------
// ittf_pkg
// shared types, constants and the digit character function of the
// integer to text formatter
// ----------------------------------------------------------------------------
package ittf_pkg;

    localparam int DIGIT_DEPTH = 64;
    localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 64;
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYCLES  = DATA_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_CYCLES);

    localparam logic [5:0] MAX_FIELD = 6'd60;
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_HEX = 6'd16;
    localparam logic [5:0] DEC_DIGITS = 6'd10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [5:0]        digit;
    } digit_wr_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } div_status_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] width;
        logic [5:0] prec;
        logic       zpad;
        logic       left;
        logic [7:0] sign_ch;
        logic       sign_len;
        logic [1:0] alt_len;
        logic       upper;
    } fmt_cfg_t;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] ch;
        if (d < DEC_DIGITS)
        begin
            ch = CH_ZERO + {2'b00, d};
        end
        else
        begin
            ch = (upper ? CH_A_UP : CH_A_LO) + {2'b00, d} - {2'b00, DEC_DIGITS};
        end
        return ch;
    endfunction

endpackage

// ----- design/ittf_divider.sv -----
// ----------------------------------------------------------------------------
// ittf_divider
// iterative radix divider, eight restoring steps per cycle, one digit
// (remainder) written to the digit store after each full pass over the dividend
// ----------------------------------------------------------------------------
module ittf_divider
    import ittf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [5:0]        radix,
    output digit_wr_t         wr,
    output div_status_t       status
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } div_state_t;

    div_state_t        state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [5:0]        rem_reg;
    logic [5:0]        radix_reg;

    logic [6:0]        rem_tmp;
    logic [DATA_W-1:0] dvd_tmp;
    logic              digit_last;
    logic              finish;

    always_comb
    begin
        rem_tmp = {1'b0, rem_reg};
        dvd_tmp = dvd_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            rem_tmp = {rem_tmp[5:0], dvd_tmp[DATA_W-1]};
            dvd_tmp = {dvd_tmp[DATA_W-2:0], 1'b0};
            if (rem_tmp >= {1'b0, radix_reg})
            begin
                rem_tmp    = rem_tmp - {1'b0, radix_reg};
                dvd_tmp[0] = 1'b1;
            end
        end
    end

    assign digit_last = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign wr.we      = (state_reg == D_RUN) && digit_last;
    assign wr.addr    = cnt_reg[ADDR_W-1:0];
    assign wr.digit   = rem_tmp[5:0];
    assign finish     = wr.we && ((dvd_tmp == '0) || (cnt_reg == CNT_W'(DIGIT_DEPTH - 1)));

    assign status.done  = done_reg;
    assign status.count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    step_reg <= digit_last ? '0 : step_reg + 1'b1;
                    if (digit_last)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (finish)
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == D_IDLE) && start)
        begin
            dvd_reg   <= dividend;
            rem_reg   <= '0;
            radix_reg <= radix;
        end
        else if (state_reg == D_RUN)
        begin
            dvd_reg <= dvd_tmp;
            rem_reg <= digit_last ? '0 : rem_tmp[5:0];
        end
    end

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_RUN) |-> (rem_reg < radix_reg))
        else $error("remainder not below radix");

    a_done_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (status.count != '0))
        else $error("division finished with no digits");

endmodule

// ----- design/ittf_emitter.sv -----
// ----------------------------------------------------------------------------
// ittf_emitter
// digit store, field layout and character sequencer with the output
// word register
// ----------------------------------------------------------------------------
module ittf_emitter
    import ittf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  digit_wr_t        wr,
    input  logic             start,
    input  fmt_cfg_t         cfg,
    input  logic [CNT_W-1:0] dcount,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [7:0]       out_char,
    output logic             last,
    output logic             bad_radix,
    output logic             truncated,
    output logic             done
);

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_SETUP = 3'b010,
        E_EMIT  = 3'b100
    } emit_state_t;

    emit_state_t       state_reg;
    fmt_cfg_t          cfg_reg;
    logic [CNT_W-1:0]  dc_reg;
    logic [CNT_W-1:0]  b1_reg, b2_reg, b3_reg, b5_reg, b6_reg, total_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] dig_idx_reg;
    logic [ADDR_W-1:0] dig_idx_next;
    logic [5:0]        rd_data_reg;
    logic [5:0]        mem [DIGIT_DEPTH];

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              last_reg;
    logic              bad_reg;
    logic              trunc_reg;

    logic [CNT_W-1:0]  prec_eff, fixed, pad, lead, zp, trail;
    logic [CNT_W-1:0]  b1_n, b2_n, b3_n, b5_n, b6_n, total_n;
    logic [7:0]        ch;
    logic              in_digits;
    logic              load;
    logic              is_last;
    logic              is_trunc;

    // field layout
    always_comb
    begin
        prec_eff = ({1'b0, cfg_reg.prec} > dc_reg) ? {1'b0, cfg_reg.prec} : dc_reg;
        fixed    = CNT_W'(cfg_reg.sign_len) + CNT_W'(cfg_reg.alt_len) + prec_eff;
        pad      = ({1'b0, cfg_reg.width} > fixed) ? {1'b0, cfg_reg.width} - fixed : '0;
        lead     = (!cfg_reg.zpad && !cfg_reg.left) ? pad : '0;
        zp       = cfg_reg.zpad ? pad : '0;
        trail    = cfg_reg.left ? pad : '0;
        b1_n     = lead;
        b2_n     = b1_n + CNT_W'(cfg_reg.sign_len);
        b3_n     = b2_n + CNT_W'(cfg_reg.alt_len);
        b5_n     = b3_n + zp + (prec_eff - dc_reg);
        b6_n     = b5_n + dc_reg;
        total_n  = cfg_reg.bad ? CNT_W'(1) : b6_n + trail;
    end

    // character at the current position
    always_comb
    begin
        in_digits = (pos_reg >= b5_reg) && (pos_reg < b6_reg);
        if (cfg_reg.bad)
        begin
            ch = CH_NUL;
        end
        else if (pos_reg < b1_reg)
        begin
            ch = CH_SPACE;
        end
        else if (pos_reg < b2_reg)
        begin
            ch = cfg_reg.sign_ch;
        end
        else if (pos_reg < b3_reg)
        begin
            ch = (pos_reg == b2_reg) ? CH_ZERO : (cfg_reg.upper ? CH_X_UP : CH_X_LO);
        end
        else if (pos_reg < b5_reg)
        begin
            ch = CH_ZERO;
        end
        else if (in_digits)
        begin
            ch = digit_char(rd_data_reg, cfg_reg.upper);
        end
        else
        begin
            ch = CH_SPACE;
        end
    end

    assign load     = (state_reg == E_EMIT) && (!out_valid_reg || !out_stall);
    assign is_last  = cfg_reg.bad || (pos_reg == total_reg - 1'b1)
                      || (pos_reg == CNT_W'(DIGIT_DEPTH - 1));
    assign is_trunc = !cfg_reg.bad && (pos_reg == CNT_W'(DIGIT_DEPTH - 1))
                      && (total_reg > CNT_W'(DIGIT_DEPTH));
    assign done     = load && is_last;

    always_comb
    begin
        dig_idx_next = dig_idx_reg;
        if (state_reg == E_SETUP)
        begin
            dig_idx_next = ADDR_W'(dc_reg - 1'b1);
        end
        else if (load && in_digits)
        begin
            dig_idx_next = dig_idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.digit;
        end
        rd_data_reg <= mem[dig_idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= E_SETUP;
                    end
                end
                E_SETUP:
                begin
                    pos_reg   <= '0;
                    state_reg <= E_EMIT;
                end
                E_EMIT:
                begin
                    if (load)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (is_last)
                        begin
                            state_reg <= E_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == E_IDLE) && start)
        begin
            cfg_reg <= cfg;
            dc_reg  <= dcount;
        end
        if (state_reg == E_SETUP)
        begin
            b1_reg    <= b1_n;
            b2_reg    <= b2_n;
            b3_reg    <= b3_n;
            b5_reg    <= b5_n;
            b6_reg    <= b6_n;
            total_reg <= total_n;
        end
        dig_idx_reg <= dig_idx_next;
        if (load)
        begin
            out_char_reg <= ch;
            last_reg     <= is_last;
            bad_reg      <= cfg_reg.bad;
            trunc_reg    <= is_trunc;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;
    assign truncated = trunc_reg;

    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && truncated) |-> last)
        else $error("truncated word not marked last");

    a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_EMIT) |-> (pos_reg < total_reg))
        else $error("position ran past end of run");

endmodule

// ----- design/integer_to_text_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_text_formatter_unit
// formats one 64-bit integer per input word into ascii output words
// each word: the divider produces D digits (1 to 64) at 8 quotient bits per cycle,
//   then N characters (1 to 64) are emitted at one character a cycle with no output
//   stalls; no new input word is accepted while a word is being divided or emitted
// bad radix: a single error character marked last, and the divider is not started
// reset: asynchronous active low, clears control state; digit store not cleared
// ----------------------------------------------------------------------------
module integer_to_text_formatter_unit
    import ittf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] value,
    input  logic [5:0]        radix,
    input  logic [5:0]        min_width,
    input  logic [5:0]        min_digits,
    input  logic              zero_pad,
    input  logic              is_signed,
    input  logic              force_plus,
    input  logic              space_sign,
    input  logic              left_justify,
    input  logic              alt_form,
    input  logic              upper_case,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_char,
    output logic              last,
    output logic              bad_radix,
    output logic              truncated
);

    typedef enum logic [2:0] {
        T_IDLE   = 3'b001,
        T_DIVIDE = 3'b010,
        T_EMIT   = 3'b100
    } top_state_t;

    top_state_t        state_reg;
    fmt_cfg_t          cfg_reg;
    fmt_cfg_t          cfg_next;
    logic [DATA_W-1:0] mag;
    logic              neg;
    logic              accept;
    logic              div_start;
    logic              em_start;
    logic              em_done;
    digit_wr_t         dig_wr;
    div_status_t       dv_status;

    assign in_stall = (state_reg != T_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        neg              = is_signed && value[DATA_W-1];
        mag              = neg ? (DATA_W'(0) - value) : value;
        cfg_next.bad     = (radix < RADIX_MIN) || (radix > RADIX_MAX);
        cfg_next.width   = (min_width > MAX_FIELD) ? MAX_FIELD : min_width;
        cfg_next.prec    = (min_digits > MAX_FIELD) ? MAX_FIELD : min_digits;
        cfg_next.left    = left_justify;
        cfg_next.zpad    = zero_pad && !left_justify;
        cfg_next.upper   = upper_case;
        cfg_next.sign_len = 1'b1;
        if (neg)
        begin
            cfg_next.sign_ch = CH_MINUS;
        end
        else if (is_signed && force_plus)
        begin
            cfg_next.sign_ch = CH_PLUS;
        end
        else if (is_signed && space_sign)
        begin
            cfg_next.sign_ch = CH_SPACE;
        end
        else
        begin
            cfg_next.sign_ch  = CH_NUL;
            cfg_next.sign_len = 1'b0;
        end
        if (alt_form && (radix == RADIX_HEX))
        begin
            cfg_next.alt_len = 2'd2;
        end
        else if (alt_form && (radix == RADIX_OCT))
        begin
            cfg_next.alt_len = 2'd1;
        end
        else
        begin
            cfg_next.alt_len = 2'd0;
        end
    end

    assign div_start = accept && !cfg_next.bad;
    assign em_start  = (state_reg == T_DIVIDE) && (cfg_reg.bad || dv_status.done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= T_DIVIDE;
                    end
                end
                T_DIVIDE:
                begin
                    if (em_start)
                    begin
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (em_done)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cfg_reg <= cfg_next;
        end
    end

    ittf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .radix    (radix),
        .wr       (dig_wr),
        .status   (dv_status)
    );

    ittf_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (dig_wr),
        .start     (em_start),
        .cfg       (cfg_reg),
        .dcount    (dv_status.count),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last      (last),
        .bad_radix (bad_radix),
        .truncated (truncated),
        .done      (em_done)
    );

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        dv_status.done |-> (state_reg == T_DIVIDE))
        else $error("divider finished outside divide state");

    a_emit_done_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        em_done |-> (state_reg == T_EMIT))
        else $error("emitter finished outside emit state");

    a_bad_word_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_radix) |-> (last && (out_char == CH_NUL)))
        else $error("malformed bad radix word");

endmodule

// ----- verif/integer_to_text_formatter_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter_unit_tb
// directed and random formatting words with random gaps and stalls on both
// sides, every character word checked against a behavioral formatter
// ----------------------------------------------------------------------------
module integer_to_text_formatter_unit_tb;
    import ittf_pkg::*;

    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int DRAIN_CYCLES = 700;
    localparam int RANDOM_WORDS = 480;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [5:0]        radix;
        logic [5:0]        min_width;
        logic [5:0]        min_digits;
        logic              zero_pad;
        logic              is_signed;
        logic              force_plus;
        logic              space_sign;
        logic              left_justify;
        logic              alt_form;
        logic              upper_case;
    } fmt_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
        logic       trunc;
    } text_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       last;
    logic       bad_radix;
    logic       truncated;
    fmt_word_t  drv_word = '0;

    fmt_word_t  pending_words[$];
    text_char_t expected_text[$];
    text_char_t seen_char;
    text_char_t want_char;

    int  gap_in = 0;
    int  stall_left = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;
    int  words_sent = 0;
    int  chars_checked = 0;
    int  bad_seen = 0;
    int  trunc_seen = 0;
    int  errors = 0;

    integer_to_text_formatter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (drv_word.value),
        .radix        (drv_word.radix),
        .min_width    (drv_word.min_width),
        .min_digits   (drv_word.min_digits),
        .zero_pad     (drv_word.zero_pad),
        .is_signed    (drv_word.is_signed),
        .force_plus   (drv_word.force_plus),
        .space_sign   (drv_word.space_sign),
        .left_justify (drv_word.left_justify),
        .alt_form     (drv_word.alt_form),
        .upper_case   (drv_word.upper_case),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last         (last),
        .bad_radix    (bad_radix),
        .truncated    (truncated)
    );

    always #5 clk = ~clk;

    // expected characters of one formatted number
    function automatic void predict_text(input fmt_word_t w);
        logic [DATA_W-1:0] mag;
        logic [5:0]        digs[DIGIT_DEPTH];
        logic [5:0]        d;
        logic [7:0]        sign_ch;
        logic [7:0]        chars[$];
        logic              zp;
        int                ndig;
        int                width;
        int                prec;
        int                rest;
        int                pad;
        int                k;
        int                n;
        text_char_t        c;
        if (w.radix < RADIX_MIN || w.radix > RADIX_MAX)
        begin
            expected_text.push_back('{CH_NUL, 1'b1, 1'b1, 1'b0});
            return;
        end
        zp = w.zero_pad && !w.left_justify;
        width = (w.min_width > MAX_FIELD) ? int'(MAX_FIELD) : int'(w.min_width);
        prec = (w.min_digits > MAX_FIELD) ? int'(MAX_FIELD) : int'(w.min_digits);
        rest = width;
        mag = w.value;
        sign_ch = CH_NUL;
        if (w.is_signed)
        begin
            if (w.value[DATA_W-1])
            begin
                sign_ch = CH_MINUS;
                mag = -w.value;
            end
            else if (w.force_plus)
            begin
                sign_ch = CH_PLUS;
            end
            else if (w.space_sign)
            begin
                sign_ch = CH_SPACE;
            end
        end
        if (sign_ch != CH_NUL)
        begin
            rest--;
        end
        if (w.alt_form && w.radix == RADIX_HEX)
        begin
            rest -= 2;
        end
        else if (w.alt_form && w.radix == RADIX_OCT)
        begin
            rest -= 1;
        end
        ndig = 0;
        if (mag == 0)
        begin
            digs[0] = '0;
            ndig = 1;
        end
        while (mag != 0)
        begin
            digs[ndig] = 6'(mag % w.radix);
            mag = mag / w.radix;
            ndig++;
        end
        if (ndig > prec)
        begin
            prec = ndig;
        end
        rest -= prec;
        pad = (rest > 0) ? rest : 0;
        if (!zp && !w.left_justify)
        begin
            for (k = 0; k < pad; k++) chars.push_back(CH_SPACE);
        end
        if (sign_ch != CH_NUL)
        begin
            chars.push_back(sign_ch);
        end
        if (w.alt_form && (w.radix == RADIX_OCT || w.radix == RADIX_HEX))
        begin
            chars.push_back(CH_ZERO);
            if (w.radix == RADIX_HEX)
            begin
                chars.push_back(w.upper_case ? CH_X_UP : CH_X_LO);
            end
        end
        if (zp)
        begin
            for (k = 0; k < pad; k++) chars.push_back(CH_ZERO);
        end
        for (k = ndig; k < prec; k++) chars.push_back(CH_ZERO);
        for (k = ndig - 1; k >= 0; k--)
        begin
            d = digs[k];
            if (d < 10)
            begin
                chars.push_back(CH_ZERO + 8'(d));
            end
            else
            begin
                chars.push_back((w.upper_case ? CH_A_UP : CH_A_LO) + 8'(d) - 8'd10);
            end
        end
        if (w.left_justify)
        begin
            for (k = 0; k < pad; k++) chars.push_back(CH_SPACE);
        end
        n = (chars.size() > DIGIT_DEPTH) ? DIGIT_DEPTH : chars.size();
        for (k = 0; k < n; k++)
        begin
            c = '{chars[k], 1'b0, 1'b0, 1'b0};
            if (k == n - 1)
            begin
                c.last = 1'b1;
                c.trunc = (chars.size() > DIGIT_DEPTH);
            end
            expected_text.push_back(c);
        end
    endfunction

    function automatic fmt_word_t fmt_item(input logic [63:0] v, input int r, input int fw,
                                           input int md, input bit zp, input bit sg,
                                           input bit pl, input bit sp, input bit lj,
                                           input bit af, input bit uc);
        fmt_word_t w;
        w = '{v, 6'(r), 6'(fw), 6'(md), zp, sg, pl, sp, lj, af, uc};
        return w;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: v = 64'($urandom_range(0, 1000));
            1: v = -64'($urandom_range(1, 1000));
            2: v = v >> $urandom_range(0, 63);
            3: v = 64'd1 << $urandom_range(0, 63);
            4: v = {1'b1, 63'($urandom_range(0, 3))};
            default: ;
        endcase
        return v;
    endfunction

    function automatic fmt_word_t random_word();
        fmt_word_t w;
        int        r;
        w.value = random_value();
        r = $urandom_range(0, 99);
        if (r < 4) w.radix = 6'($urandom_range(0, 1));
        else if (r < 10) w.radix = 6'($urandom_range(37, 63));
        else if (r < 25) w.radix = RADIX_HEX;
        else if (r < 40) w.radix = RADIX_OCT;
        else if (r < 55) w.radix = 6'd10;
        else if (r < 65) w.radix = RADIX_MIN;
        else w.radix = 6'($urandom_range(2, 36));
        r = $urandom_range(0, 99);
        if (r < 50) w.min_width = 6'($urandom_range(0, 12));
        else if (r < 85) w.min_width = 6'($urandom_range(0, 30));
        else w.min_width = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 50) w.min_digits = '0;
        else if (r < 85) w.min_digits = 6'($urandom_range(0, 24));
        else w.min_digits = 6'($urandom_range(0, 63));
        {w.zero_pad, w.is_signed, w.force_plus, w.space_sign,
         w.left_justify, w.alt_form, w.upper_case} = 7'($urandom);
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input text_char_t e, input text_char_t g);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%s at cycle %0d: expected %h %b %b %b, got %h %b %b %b (char last bad trunc)",
                     what, cycle_count, e.ch, e.last, e.bad, e.trunc,
                     g.ch, g.last, g.bad, g.trunc);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0)
        begin
            quiet <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_word <= '0;
            gap_in <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_text(drv_word);
                words_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_in > 0)
                begin
                    in_valid <= 1'b0;
                    gap_in <= gap_in - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    drv_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    gap_in <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // character monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_char = '{out_char, last, bad_radix, truncated};
            if (seen_char.bad) bad_seen++;
            if (seen_char.trunc) trunc_seen++;
            if (expected_text.size() == 0)
            begin
                report_mismatch("unexpected word", '0, seen_char);
            end
            else
            begin
                want_char = expected_text.pop_front();
                chars_checked++;
                if (seen_char != want_char)
                begin
                    report_mismatch("mismatch", want_char, seen_char);
                end
            end
        end
    end

    initial
    begin
        int i;
        // extremes, bad radices and special cases
        pending_words.push_back(fmt_item(64'd0, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(64'd7, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(64'd7, 1, 0, 0, 1, 1, 1, 1, 1, 1, 1));
        pending_words.push_back(fmt_item(64'd7, 37, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item('1, 63, 63, 63, 1, 1, 1, 1, 1, 1, 1));
        pending_words.push_back(fmt_item(64'h8000_0000_0000_0000, 2, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(64'h8000_0000_0000_0000, 10, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item('1, 2, 63, 63, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item('1, 10, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(64'h7fff_ffff_ffff_ffff, 2, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(64'd255, 16, 10, 0, 1, 0, 0, 0, 0, 1, 1));
        pending_words.push_back(fmt_item(64'd0, 16, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_words.push_back(fmt_item(64'd0, 8, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_words.push_back(fmt_item(64'd42, 10, 8, 0, 0, 1, 0, 1, 0, 0, 0));
        pending_words.push_back(fmt_item(64'd42, 10, 63, 0, 1, 1, 1, 0, 1, 0, 0));
        pending_words.push_back(fmt_item(64'd123, 10, 63, 63, 1, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(64'd35, 36, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_words.push_back(fmt_item(64'd35, 36, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(-64'd5, 16, 12, 4, 1, 1, 0, 0, 0, 1, 0));
        pending_words.push_back(fmt_item(64'd9, 10, 6, 0, 0, 1, 1, 1, 0, 0, 0));
        pending_words.push_back(fmt_item(64'd100, 10, 8, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_words.push_back(fmt_item(64'hdead_beef, 8, 20, 15, 1, 0, 0, 0, 0, 1, 0));
        pending_words.push_back(fmt_item(64'h0123_4567_89ab_cdef, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(fmt_item(-64'd1000, 10, 40, 50, 0, 1, 0, 0, 1, 0, 0));
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            pending_words.push_back(random_word());
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || in_valid) @(posedge clk);
        while (expected_text.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_text.size() != 0)
        begin
            errors += expected_text.size();
        end
        $display("formatted %0d numbers into %0d checked chars in %0d cycles",
                 words_sent, chars_checked, cycle_count);
        $display("bad radix words: %0d, runs cut at 64 chars: %0d, mismatches: %0d",
                 bad_seen, trunc_seen, errors);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
